/* sv/ptds_pkg.sv */
// Package with shared types, constants and the arctangent table of the step planner.
`timescale 1ns / 1ps
`default_nettype none
package ptds_pkg;

  localparam int STEP_W  = 22;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 45;
  localparam int IDX_W   = 5;
  localparam int XW      = 36;
  localparam int ZW      = 33;
  localparam int CNT_W   = 5;

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032875;
  localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
  localparam logic [31:0] TURN_DEN_K   = 32'd4500;
  localparam logic [ZW-1:0] HALF_TURN  = 33'd1179648000;

  localparam logic [0:0] REG_BASE   = 1'b0;
  localparam logic [0:0] REG_RADIUS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CGO, ST_CWAIT, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
    ST_M6, ST_M7, ST_DTGO, ST_DTWAIT, ST_DDGO, ST_DDWAIT, ST_FIN
  } state_t;

  function automatic logic [31:0] atan_q16(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd294912000;
      5'd1:  v = 32'd174096719;
      5'd2:  v = 32'd91987925;
      5'd3:  v = 32'd46694507;
      5'd4:  v = 32'd23437865;
      5'd5:  v = 32'd11730358;
      5'd6:  v = 32'd5866610;
      5'd7:  v = 32'd2933484;
      5'd8:  v = 32'd1466764;
      5'd9:  v = 32'd733385;
      5'd10: v = 32'd366693;
      5'd11: v = 32'd183346;
      5'd12: v = 32'd91673;
      5'd13: v = 32'd45837;
      5'd14: v = 32'd22918;
      5'd15: v = 32'd11459;
      5'd16: v = 32'd5730;
      5'd17: v = 32'd2865;
      5'd18: v = 32'd1432;
      5'd19: v = 32'd716;
      5'd20: v = 32'd358;
      5'd21: v = 32'd179;
      5'd22: v = 32'd90;
      5'd23: v = 32'd45;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/pose_to_turn_and_drive_steps_core.sv */
// Top level of the turn-then-drive step planner with its sequencer.
// Input words carry a target point (mode 0) or a pose to load (mode 1); each
// input word yields exactly one output word with the turn direction, the turn
// and drive microstep counts and a saturation flag. Configuration writes set
// the wheel base and the wheel radius and must only be made while no word is in flight.
// A move word passes through the CORDIC pass, seven products and two divisions
// before its result reaches the output register: the CORDIC unit runs one
// rotation per cycle, seven products go through the shared multiplier one per
// cycle, and the two divisions share one divider that yields its 23 quotient
// bits. When the target equals the pose the CORDIC pass is skipped.
// A load word goes from idle straight to the finish state, which fills the output
// register once it is free, and the sequencer then returns to idle for the next
// word. in_tready is high only while the sequencer is idle.
// The result sits in an output register; a new word is accepted while it waits,
// and the next result is held internally until out_tready takes the old one.
// Reset clears the pose to zero, restores the default configuration and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module pose_to_turn_and_drive_steps_core #(
  parameter int STEPS_PER_REV     = 3200,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // target_x [14:0], target_y [29:15], load_heading [45:30]
  input  wire logic [47:0] in_tdata,
  // mode [0]
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // turn_steps [21:0], drive_steps [43:22]
  output logic [47:0]      out_tdata,
  // turn_clockwise [0], saturated [1]
  output logic [1:0]       out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  localparam int SW = ptds_pkg::STEP_W;

  ptds_pkg::state_t state_r, state_nxt;

  logic signed [14:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic signed [14:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic signed [15:0] pose_h_r, pose_h_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic [11:0]        base_r;
  logic [13:0]        rad_r;
  logic signed [ptds_pkg::XW-1:0] xfin_r, xfin_nxt, c_x;
  logic signed [ptds_pkg::ZW-1:0] c_z, zr;
  logic signed [16:0] bear_r, bear_nxt;
  logic signed [17:0] turn;
  logic [17:0]        mag_r, mag_nxt;
  logic               cw_r, cw_nxt;
  logic [63:0]        p0_r, p0_nxt, mul_p, dsum;
  logic [31:0]        dist_r, dist_nxt, mul_a, mul_b;
  logic [26:0]        sb_r, sb_nxt, tden_r, tden_nxt;
  logic [44:0]        dden_r, dden_nxt, tnum_r, tnum_nxt;
  logic [62:0]        dnum_r, dnum_nxt;
  logic [SW-1:0]      ts_r, ts_nxt, ds_r, ds_nxt, div_q;
  logic               tsat_r, tsat_nxt, sat_r, sat_nxt;
  logic [SW-1:0]      o_ts_r, o_ts_nxt, o_ds_r, o_ds_nxt;
  logic               o_cw_r, o_cw_nxt, o_sat_r, o_sat_nxt, o_v_r, o_v_nxt;
  logic               c_start, c_done, d_start, d_done, d_sat, accept, zero_vec;
  logic [ptds_pkg::NUM_W-1:0] d_num;
  logic [ptds_pkg::DEN_W-1:0] d_den;

  assign accept   = in_tvalid && in_tready;
  assign zero_vec = (dx_r == '0) && (dy_r == '0);
  assign zr       = c_z + ptds_pkg::ZW'(32768);
  assign turn     = 18'(bear_r) - 18'(pose_h_r);
  assign dsum     = p0_r + {mul_p[31:0], 32'b0};

  ptds_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  ptds_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .dx(dx_r), .dy(dy_r),
    .done(c_done), .x_out(c_x), .z_out(c_z)
  );

  ptds_div u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num), .den(d_den),
    .done(d_done), .q(div_q), .sat(d_sat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptds_pkg::ST_IDLE:   if (accept) state_nxt = in_tuser[0] ? ptds_pkg::ST_FIN
                                                               : ptds_pkg::ST_CGO;
      ptds_pkg::ST_CGO:    state_nxt = zero_vec ? ptds_pkg::ST_M0 : ptds_pkg::ST_CWAIT;
      ptds_pkg::ST_CWAIT:  if (c_done) state_nxt = ptds_pkg::ST_M0;
      ptds_pkg::ST_M0:     state_nxt = ptds_pkg::ST_M1;
      ptds_pkg::ST_M1:     state_nxt = ptds_pkg::ST_M2;
      ptds_pkg::ST_M2:     state_nxt = ptds_pkg::ST_M3;
      ptds_pkg::ST_M3:     state_nxt = ptds_pkg::ST_M4;
      ptds_pkg::ST_M4:     state_nxt = ptds_pkg::ST_M5;
      ptds_pkg::ST_M5:     state_nxt = ptds_pkg::ST_M6;
      ptds_pkg::ST_M6:     state_nxt = ptds_pkg::ST_M7;
      ptds_pkg::ST_M7:     state_nxt = ptds_pkg::ST_DTGO;
      ptds_pkg::ST_DTGO:   state_nxt = ptds_pkg::ST_DTWAIT;
      ptds_pkg::ST_DTWAIT: if (d_done) state_nxt = ptds_pkg::ST_DDGO;
      ptds_pkg::ST_DDGO:   state_nxt = ptds_pkg::ST_DDWAIT;
      ptds_pkg::ST_DDWAIT: if (d_done) state_nxt = ptds_pkg::ST_FIN;
      ptds_pkg::ST_FIN:    if (!o_v_r || out_tready) state_nxt = ptds_pkg::ST_IDLE;
      default:             state_nxt = ptds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ptds_pkg::ST_IDLE);
    pose_x_nxt = pose_x_r;  pose_y_nxt = pose_y_r;  pose_h_nxt = pose_h_r;
    tgt_x_nxt = tgt_x_r;    tgt_y_nxt = tgt_y_r;
    dx_nxt = dx_r;          dy_nxt = dy_r;
    xfin_nxt = xfin_r;      bear_nxt = bear_r;
    mag_nxt = mag_r;        cw_nxt = cw_r;
    p0_nxt = p0_r;          dist_nxt = dist_r;   sb_nxt = sb_r;
    dden_nxt = dden_r;      dnum_nxt = dnum_r;   tnum_nxt = tnum_r;  tden_nxt = tden_r;
    ts_nxt = ts_r;          ds_nxt = ds_r;       tsat_nxt = tsat_r;  sat_nxt = sat_r;
    o_ts_nxt = o_ts_r;      o_ds_nxt = o_ds_r;   o_cw_nxt = o_cw_r;  o_sat_nxt = o_sat_r;
    o_v_nxt = o_v_r && !out_tready;
    mul_a = '0;             mul_b = '0;
    c_start = 1'b0;         d_start = 1'b0;
    d_num = '0;             d_den = '0;
    unique case (state_r)
      ptds_pkg::ST_IDLE: begin
        if (accept) begin
          tgt_x_nxt = in_tdata[14:0];
          tgt_y_nxt = in_tdata[29:15];
          dx_nxt = 16'(signed'(in_tdata[14:0])) - 16'(pose_x_r);
          dy_nxt = 16'(signed'(in_tdata[29:15])) - 16'(pose_y_r);
          if (in_tuser[0]) begin
            pose_x_nxt = in_tdata[14:0];
            pose_y_nxt = in_tdata[29:15];
            pose_h_nxt = in_tdata[45:30];
            ts_nxt = '0;  ds_nxt = '0;  cw_nxt = 1'b0;  sat_nxt = 1'b0;
          end
        end
      end
      ptds_pkg::ST_CGO: begin
        if (zero_vec) begin
          xfin_nxt = '0;
          bear_nxt = '0;
        end else begin
          c_start = 1'b1;
        end
      end
      ptds_pkg::ST_CWAIT: begin
        if (c_done) begin
          xfin_nxt = c_x[ptds_pkg::XW-1] ? '0 : c_x;
          bear_nxt = zr[32:16];
        end
      end
      ptds_pkg::ST_M0: begin
        cw_nxt  = !turn[17];
        mag_nxt = turn[17] ? 18'(-turn) : 18'(turn);
        mul_a = xfin_r[31:0];
        mul_b = ptds_pkg::INV_GAIN_Q30;
      end
      ptds_pkg::ST_M1: begin
        p0_nxt = mul_p;
        mul_a = 32'(xfin_r[ptds_pkg::XW-1:32]);
        mul_b = ptds_pkg::INV_GAIN_Q30;
      end
      ptds_pkg::ST_M2: begin
        dist_nxt = dsum[61:30];
        mul_a = 32'(STEPS_PER_REV);
        mul_b = 32'(base_r);
      end
      ptds_pkg::ST_M3: begin
        sb_nxt = mul_p[26:0];
        mul_a = ptds_pkg::TWO_PI_Q28;
        mul_b = 32'(rad_r);
      end
      ptds_pkg::ST_M4: begin
        dden_nxt = mul_p[44:0];
        mul_a = 32'(STEPS_PER_REV);
        mul_b = dist_r;
      end
      ptds_pkg::ST_M5: begin
        dnum_nxt = {mul_p[46:0], 16'b0};
        mul_a = 32'(sb_r);
        mul_b = 32'(mag_r);
      end
      ptds_pkg::ST_M6: begin
        tnum_nxt = mul_p[44:0];
        mul_a = ptds_pkg::TURN_DEN_K;
        mul_b = 32'(rad_r);
      end
      ptds_pkg::ST_M7: begin
        tden_nxt = mul_p[26:0];
      end
      ptds_pkg::ST_DTGO: begin
        d_start = 1'b1;
        d_num = 64'(tnum_r);
        d_den = 45'(tden_r);
      end
      ptds_pkg::ST_DTWAIT: begin
        if (d_done) begin
          ts_nxt   = div_q;
          tsat_nxt = d_sat;
        end
      end
      ptds_pkg::ST_DDGO: begin
        d_start = 1'b1;
        d_num = 64'(dnum_r);
        d_den = dden_r;
      end
      ptds_pkg::ST_DDWAIT: begin
        if (d_done) begin
          ds_nxt  = div_q;
          sat_nxt = tsat_r || d_sat;
          pose_x_nxt = tgt_x_r;
          pose_y_nxt = tgt_y_r;
          pose_h_nxt = bear_r[15:0];
        end
      end
      ptds_pkg::ST_FIN: begin
        if (!o_v_r || out_tready) begin
          o_ts_nxt  = ts_r;
          o_ds_nxt  = ds_r;
          o_cw_nxt  = cw_r;
          o_sat_nxt = sat_r;
          o_v_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tgt_x_r <= tgt_x_nxt;  tgt_y_r <= tgt_y_nxt;
    dx_r <= dx_nxt;        dy_r <= dy_nxt;
    xfin_r <= xfin_nxt;    bear_r <= bear_nxt;
    mag_r <= mag_nxt;      cw_r <= cw_nxt;
    p0_r <= p0_nxt;        dist_r <= dist_nxt;   sb_r <= sb_nxt;
    dden_r <= dden_nxt;    dnum_r <= dnum_nxt;   tnum_r <= tnum_nxt;  tden_r <= tden_nxt;
    ts_r <= ts_nxt;        ds_r <= ds_nxt;       tsat_r <= tsat_nxt;  sat_r <= sat_nxt;
    o_ts_r <= o_ts_nxt;    o_ds_r <= o_ds_nxt;   o_cw_r <= o_cw_nxt;  o_sat_r <= o_sat_nxt;
    if (!rst_n) begin
      state_r  <= ptds_pkg::ST_IDLE;
      pose_x_r <= '0;
      pose_y_r <= '0;
      pose_h_r <= '0;
      base_r   <= 12'd250;
      rad_r    <= 14'd640;
      o_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pose_x_r <= pose_x_nxt;
      pose_y_r <= pose_y_nxt;
      pose_h_r <= pose_h_nxt;
      o_v_r    <= o_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ptds_pkg::REG_BASE:   base_r <= cfg_data[11:0];
          ptds_pkg::REG_RADIUS: rad_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {4'b0, o_ds_r, o_ts_r};
  assign out_tuser  = {o_sat_r, o_cw_r};

endmodule
`default_nettype wire

/* sv/ptds_mul.sv */
// Shared 32 by 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module ptds_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

/* sv/ptds_cordic.sv */
// Iterative CORDIC vectoring unit, one rotation per cycle through a shared shifter.
`timescale 1ns / 1ps
`default_nettype none
module ptds_cordic #(
  parameter int ITERS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [15:0]           dx,
  input  wire logic signed [15:0]           dy,
  output logic                              done,
  output logic signed [ptds_pkg::XW-1:0]    x_out,
  output logic signed [ptds_pkg::ZW-1:0]    z_out
);

  logic signed [ptds_pkg::XW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys, x0, y0;
  logic signed [ptds_pkg::ZW-1:0] z_r, z_nxt, z0, at;
  logic [ptds_pkg::IDX_W-1:0]     i_r, i_nxt;
  logic                           busy_r, busy_nxt, done_r, done_nxt;
  logic signed [16:0]             dxn, dyn;

  always_comb begin
    dxn = dx[15] ? -17'(dx) : 17'(dx);
    dyn = dx[15] ? -17'(dy) : 17'(dy);
    x0  = {{3{dxn[16]}}, dxn, 16'b0};
    y0  = {{3{dyn[16]}}, dyn, 16'b0};
    if (!dx[15]) begin
      z0 = '0;
    end else if (!dy[15]) begin
      z0 = ptds_pkg::HALF_TURN;
    end else begin
      z0 = -ptds_pkg::HALF_TURN;
    end
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({1'b0, ptds_pkg::atan_q16(i_r)});
  end

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = z0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[ptds_pkg::XW-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end
      if (i_r == ptds_pkg::IDX_W'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule
`default_nettype wire

/* sv/ptds_div.sv */
// Restoring divider, one quotient bit per cycle, with saturation at the step maximum.
`timescale 1ns / 1ps
`default_nettype none
module ptds_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ptds_pkg::NUM_W-1:0]    num,
  input  wire logic [ptds_pkg::DEN_W-1:0]    den,
  output logic                               done,
  output logic [ptds_pkg::STEP_W-1:0]        q,
  output logic                               sat
);

  localparam int DW = ptds_pkg::DEN_W + ptds_pkg::STEP_W;

  logic [ptds_pkg::NUM_W-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]               dsh_r, dsh_nxt;
  logic [ptds_pkg::STEP_W:0]   q_r, q_nxt;
  logic [ptds_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ge       = DW'(rem_r) >= dsh_r;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, ptds_pkg::STEP_W'(0)};
      q_nxt    = '0;
      cnt_nxt  = ptds_pkg::CNT_W'(ptds_pkg::STEP_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[ptds_pkg::NUM_W-1:0];
      end
      q_nxt   = {q_r[ptds_pkg::STEP_W-1:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign sat  = q_r[ptds_pkg::STEP_W];
  assign q    = q_r[ptds_pkg::STEP_W] ? '1 : q_r[ptds_pkg::STEP_W-1:0];

endmodule
`default_nettype wire
